### rtl/core/bcc_pkg.sv
`default_nettype none
package bcc_pkg;

  // Configuration port widths
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned TimeWidth     = 32;

  // Register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEBOUNCE      = 2'd0,
    REG_DOUBLE_WINDOW = 2'd1,
    REG_LONG_PRESS    = 2'd2
  } reg_index_t;

  // Register reset values
  localparam logic [CfgDataWidth-1:0] DebounceReset     = 16'd50;
  localparam logic [CfgDataWidth-1:0] DoubleWindowReset = 16'd300;
  localparam logic [CfgDataWidth-1:0] LongPressReset    = 16'd1000;

  // Pin level meaning (active low)
  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  // Configuration values seen by the classifier
  typedef struct packed {
    logic [CfgDataWidth-1:0] debounce_ms;
    logic [CfgDataWidth-1:0] double_window_ms;
    logic [CfgDataWidth-1:0] long_press_ms;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic single_click;
    logic double_click;
    logic long_press;
    logic debounced_level;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/bcc_sample_if.sv
`default_nettype none
interface bcc_sample_if;
  import bcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 pin_level;
  logic [TimeWidth-1:0] time_ms;

  modport source (output valid, output pin_level, output time_ms, input ready);
  modport sink   (input valid, input pin_level, input time_ms, output ready);
endinterface
`default_nettype wire

### rtl/core/bcc_result_if.sv
`default_nettype none
interface bcc_result_if;
  logic valid;
  logic ready;
  logic single_click;
  logic double_click;
  logic long_press;
  logic debounced_level;

  modport source (output valid, output single_click, output double_click,
                  output long_press, output debounced_level, input ready);
  modport sink   (input valid, input single_click, input double_click,
                  input long_press, input debounced_level, output ready);
endinterface
`default_nettype wire

### rtl/core/bcc_cfg_if.sv
`default_nettype none
interface bcc_cfg_if;
  import bcc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/button_click_classifier.sv
`default_nettype none
// Button click classifier: debounces an active-low button sampled with a
// millisecond timestamp and reports single click, double click, long press
// and the debounced level.
//
// Channels (valid/ready, word moves when both are high):
//   sample : pin_level and time_ms, one word per button sample.
//   result : one word for every sample word, in order.
//   cfg    : register writes (0 debounce, 1 double window, 2 long press);
//            always ready; other indexes are dropped. Write only while idle.
//
// The result word of a sample is computed combinationally and registered into
// the output buffer when the sample is taken. The block takes one sample per
// cycle while the buffer has space. A two-word output buffer lets the block
// take a sample while a result waits; sample.ready drops only when both
// buffer words are held by a stalled receiver.
// Reset (rst, synchronous) restores register defaults, releases the button
// state and empties the output buffer.
module button_click_classifier (
  input  wire logic   clk,
  input  wire logic   rst,
  bcc_sample_if.sink  sample,
  bcc_result_if.source result,
  bcc_cfg_if.sink     cfg
);
  import bcc_pkg::*;

  cfg_t    cfg_val;
  result_t step_result;
  result_t out_word;
  logic    sample_take;
  logic    space;

  assign cfg.ready    = 1'b1;
  assign sample.ready = space;
  assign sample_take  = sample.valid && space;

  bcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_val)
  );

  bcc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .accept    (sample_take),
    .pin_level (sample.pin_level),
    .time_ms   (sample.time_ms),
    .cfg       (cfg_val),
    .result    (step_result)
  );

  bcc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (sample_take),
    .push_data (step_result),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_word)
  );

  assign result.single_click    = out_word.single_click;
  assign result.double_click    = out_word.double_click;
  assign result.long_press      = out_word.long_press;
  assign result.debounced_level = out_word.debounced_level;

endmodule
`default_nettype wire

### rtl/core/bcc_cfg_regs.sv
`default_nettype none
module bcc_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [bcc_pkg::CfgIndexWidth-1:0] wr_index,
  input  wire logic [bcc_pkg::CfgDataWidth-1:0]  wr_data,
  output bcc_pkg::cfg_t                          cfg
);
  import bcc_pkg::*;

  // Write the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms      <= DebounceReset;
      cfg.double_window_ms <= DoubleWindowReset;
      cfg.long_press_ms    <= LongPressReset;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_DEBOUNCE:      cfg.debounce_ms      <= wr_data;
        REG_DOUBLE_WINDOW: cfg.double_window_ms <= wr_data;
        REG_LONG_PRESS:    cfg.long_press_ms    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/bcc_classify.sv
`default_nettype none
module bcc_classify (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          pin_level,
  input  wire logic [bcc_pkg::TimeWidth-1:0] time_ms,
  input  wire bcc_pkg::cfg_t                 cfg,
  output bcc_pkg::result_t                   result
);
  import bcc_pkg::*;

  logic                 previous_sample;
  logic                 stable_level;
  logic [TimeWidth-1:0] last_change_time;
  logic [TimeWidth-1:0] last_press_time;
  logic                 long_flag;

  logic                 stable_level_next;
  logic [TimeWidth-1:0] last_change_time_next;
  logic [TimeWidth-1:0] last_press_time_next;
  logic                 long_flag_next;

  logic [TimeWidth-1:0] since_change;
  logic [TimeWidth-1:0] since_press;
  logic                 settled;
  logic                 single_hit;
  logic                 double_hit;

  // Restart the debounce timer on a raw level change
  assign last_change_time_next = (pin_level != previous_sample) ? time_ms : last_change_time;
  assign since_change = time_ms - last_change_time_next;
  assign since_press  = time_ms - last_press_time;
  assign settled = since_change > {{(TimeWidth-CfgDataWidth){1'b0}}, cfg.debounce_ms};

  // Accept a new stable level, classify presses, track long hold
  always_comb begin
    stable_level_next    = stable_level;
    last_press_time_next = last_press_time;
    long_flag_next       = long_flag;
    single_hit           = 1'b0;
    double_hit           = 1'b0;
    if (settled) begin
      if (pin_level != stable_level) begin
        stable_level_next = pin_level;
        if (pin_level == LevelPressed) begin
          if (since_press <= {{(TimeWidth-CfgDataWidth){1'b0}}, cfg.double_window_ms}) begin
            double_hit = 1'b1;
          end else begin
            single_hit = 1'b1;
          end
          last_press_time_next = time_ms;
        end else begin
          long_flag_next = 1'b0;
        end
      end else if (stable_level == LevelPressed &&
                   since_press > {{(TimeWidth-CfgDataWidth){1'b0}}, cfg.long_press_ms}) begin
        long_flag_next = 1'b1;
      end
    end
  end

  assign result.single_click    = single_hit;
  assign result.double_click    = double_hit;
  assign result.long_press      = long_flag_next;
  assign result.debounced_level = stable_level_next;

  // Advance state on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample  <= LevelReleased;
      stable_level     <= LevelReleased;
      last_change_time <= '0;
      last_press_time  <= '0;
      long_flag        <= 1'b0;
    end else if (accept) begin
      previous_sample  <= pin_level;
      stable_level     <= stable_level_next;
      last_change_time <= last_change_time_next;
      last_press_time  <= last_press_time_next;
      long_flag        <= long_flag_next;
    end
  end

`ifndef SYNTHESIS
  // Long press only exists while the accepted level is pressed
  a_long_needs_press: assert property (@(posedge clk) disable iff (rst)
    long_flag |-> (stable_level == LevelPressed))
    else $error("long press flag set while released");

  // A click goes with a press that was just accepted
  a_click_is_press: assert property (@(posedge clk) disable iff (rst)
    (single_hit || double_hit) |->
      (!(single_hit && double_hit) && stable_level == LevelReleased && pin_level == LevelPressed))
    else $error("click without fresh press");
`endif

endmodule
`default_nettype wire

### rtl/core/bcc_skid.sv
`default_nettype none
module bcc_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bcc_pkg::result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bcc_pkg::result_t      out_data
);
  import bcc_pkg::*;

  logic    head_valid;
  logic    spare_valid;
  result_t head;
  result_t spare;
  logic    pop;

  assign pop       = head_valid && out_ready;
  assign space     = !spare_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  // Hold the output word; park a second word while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      case ({push, pop})
        2'b11: begin
          head <= push_data;
        end
        2'b10: begin
          if (!head_valid) begin
            head       <= push_data;
            head_valid <= 1'b1;
          end else begin
            spare       <= push_data;
            spare_valid <= 1'b1;
          end
        end
        2'b01: begin
          if (spare_valid) begin
            head        <= spare;
            spare_valid <= 1'b0;
          end else begin
            head_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Spare slot fills only behind a valid head
  a_spare_behind_head: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> head_valid)
    else $error("spare word without head word");

  // A stalled full buffer keeps both words
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (spare_valid && !out_ready) |=> (spare_valid && $stable(spare) && $stable(head)))
    else $error("buffered words changed during stall");
`endif

endmodule
`default_nettype wire

### verif/tb_button_click_classifier.sv
`timescale 1ns / 1ps
module tb_button_click_classifier;
  import bcc_pkg::*;

  localparam logic [CfgIndexWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseSamples = 85;

  typedef struct packed {
    logic                 pin_level;
    logic [TimeWidth-1:0] time_ms;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bcc_sample_if sample_ch ();
  bcc_result_if result_ch ();
  bcc_cfg_if    cfg_ch ();

  button_click_classifier DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Pending sample words and predicted result words
  sample_t pending_samples[$];
  result_t expected_results[$];
  int unsigned error_count = 0;

  // Classifier state as the block should hold it
  cfg_t model_cfg = '{DebounceReset, DoubleWindowReset, LongPressReset};
  logic                 raw_prev      = LevelReleased;
  logic                 settled_level = LevelReleased;
  logic                 long_held     = 1'b0;
  logic [TimeWidth-1:0] change_ms     = '0;
  logic [TimeWidth-1:0] press_ms      = '0;

  // Pacing controls, set per phase
  bit          sender_eager = 1'b0;
  bit          receiver_eager = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned next_stall;
  int unsigned hold_left = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;
  sample_t     next_sample;

  // Stimulus time base
  logic [TimeWidth-1:0] stim_ms = '0;

  function automatic int unsigned draw_wait(input bit eager);
    if (eager || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Advance the classifier state by one sample and queue its result word
  task automatic predict_sample(input logic lvl, input logic [TimeWidth-1:0] now);
    result_t              r;
    logic [TimeWidth-1:0] since_change;
    logic [TimeWidth-1:0] since_press;
    r = '0;
    if (lvl != raw_prev) change_ms = now;
    since_change = now - change_ms;
    since_press = now - press_ms;
    if (since_change > model_cfg.debounce_ms) begin
      if (lvl != settled_level) begin
        settled_level = lvl;
        if (lvl == LevelPressed) begin
          if (since_press <= model_cfg.double_window_ms) r.double_click = 1'b1;
          else r.single_click = 1'b1;
          press_ms = now;
        end else begin
          long_held = 1'b0;
        end
      end else if (settled_level == LevelPressed &&
                   since_press > model_cfg.long_press_ms) begin
        long_held = 1'b1;
      end
    end
    raw_prev = lvl;
    r.long_press = long_held;
    r.debounced_level = settled_level;
    expected_results.push_back(r);
  endtask

  // Compare one result word against the oldest prediction
  task automatic check_result();
    result_t got;
    result_t want;
    got = {result_ch.single_click, result_ch.double_click,
           result_ch.long_press, result_ch.debounced_level};
    if (expected_results.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: result word with none expected: single=%0b double=%0b long=%0b level=%0b",
                 $realtime, got.single_click, got.double_click, got.long_press,
                 got.debounced_level);
    end else begin
      want = expected_results.pop_front();
      if (got.single_click !== want.single_click || got.double_click !== want.double_click ||
          got.long_press !== want.long_press ||
          got.debounced_level !== want.debounced_level) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: mismatch single/double/long/level: expected %0b%0b%0b%0b, got %0b%0b%0b%0b",
                   $realtime, want.single_click, want.double_click, want.long_press,
                   want.debounced_level, got.single_click, got.double_click,
                   got.long_press, got.debounced_level);
      end
    end
  endtask

  // Sample driver: predict on each accepted word, then offer the next after its gap
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.pin_level <= LevelReleased;
      sample_ch.time_ms <= '0;
      send_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready)
        predict_sample(sample_ch.pin_level, sample_ch.time_ms);
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          sample_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          next_sample = pending_samples.pop_front();
          sample_ch.valid <= 1'b1;
          sample_ch.pin_level <= next_sample.pin_level;
          sample_ch.time_ms <= next_sample.time_ms;
          send_gap <= draw_wait(sender_eager);
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      hold_left <= HoldOffCycles;
      holds_served <= holds_served + 1;
    end
  end

  // Result monitor: check each accepted word, stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      next_stall = (stall_left > 0) ? stall_left - 1 : 0;
      if (result_ch.valid && result_ch.ready) begin
        check_result();
        next_stall = draw_wait(receiver_eager);
      end
      stall_left <= next_stall;
      result_ch.ready <= (next_stall == 0) && (hold_left == 0);
    end
  end

  task automatic queue_sample(input logic lvl, input logic [TimeWidth-1:0] at_ms);
    sample_t s;
    s.pin_level = lvl;
    s.time_ms = at_ms;
    pending_samples.push_back(s);
    stim_ms = at_ms;
  endtask

  // Bounce, settle on lvl, then land on both sides of the debounce boundary
  task automatic queue_edge(input logic lvl, output logic [TimeWidth-1:0] accept_ms);
    int unsigned          deb;
    int unsigned          bounces;
    logic [TimeWidth-1:0] settle_ms;
    deb = 32'(model_cfg.debounce_ms);
    bounces = $urandom_range(0, 3);
    for (int i = 0; i < bounces; i++)
      queue_sample((i % 2) ? lvl : ~lvl, stim_ms + $urandom_range(0, deb / 2 + 1));
    queue_sample(lvl, stim_ms + $urandom_range(0, 1));
    settle_ms = stim_ms;
    if ($urandom_range(0, 1)) queue_sample(lvl, settle_ms + deb);
    accept_ms = settle_ms + deb + 1 + $urandom_range(0, 1);
    queue_sample(lvl, accept_ms);
  endtask

  // One press and release, optionally held around the long-press limit
  task automatic queue_click(input bit hold_long);
    logic [TimeWidth-1:0] down_ms;
    logic [TimeWidth-1:0] up_ms;
    int unsigned          lp;
    lp = 32'(model_cfg.long_press_ms);
    queue_edge(LevelPressed, down_ms);
    if (hold_long) begin
      queue_sample(LevelPressed, down_ms + lp);
      queue_sample(LevelPressed, down_ms + lp + 1 + $urandom_range(0, 2));
    end else if ($urandom_range(0, 1)) begin
      queue_sample(LevelPressed, stim_ms + $urandom_range(0, model_cfg.debounce_ms + 1));
    end
    queue_edge(LevelReleased, up_ms);
    // pause, often short enough for the next press to be a double click
    stim_ms = stim_ms + $urandom_range(0, model_cfg.double_window_ms + 1);
  endtask

  function automatic logic [CfgDataWidth-1:0] pick_ms(input int unsigned small_max);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CfgDataWidth'($urandom);
      default: return CfgDataWidth'($urandom_range(1, small_max));
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE:      model_cfg.debounce_ms = val;
      REG_DOUBLE_WINDOW: model_cfg.double_window_ms = val;
      REG_LONG_PRESS:    model_cfg.long_press_ms = val;
      default: ;
    endcase
  endtask

  // Wait until every word is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned pick;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: first press near time zero, long press, wrap, time going back
    @(negedge clk);
    queue_sample(LevelReleased, 32'd0);
    queue_sample(LevelPressed, 32'd10);
    queue_sample(LevelPressed, 32'd60);
    queue_sample(LevelPressed, 32'd61);
    queue_sample(LevelPressed, 32'd1062);
    queue_sample(LevelReleased, 32'd1100);
    queue_sample(LevelReleased, 32'd1151);
    queue_sample(LevelPressed, 32'd2000);
    queue_sample(LevelPressed, 32'd2051);
    queue_sample(LevelReleased, 32'd2100);
    queue_sample(LevelReleased, 32'd2151);
    queue_sample(LevelPressed, 32'hFFFF_FFFF);
    queue_sample(LevelPressed, 32'h0000_0032);
    queue_sample(LevelReleased, 32'h0000_0010);
    queue_sample(LevelReleased, 32'h0000_0000);
    wait_drained();

    // Zero delays; the unused index must be dropped
    write_reg(RegUnused, CfgDataWidth'($urandom));
    write_reg(REG_DEBOUNCE, '0);
    write_reg(REG_DOUBLE_WINDOW, '0);
    write_reg(REG_LONG_PRESS, '0);
    @(negedge clk);
    queue_sample(LevelPressed, 32'd5000);
    queue_sample(LevelPressed, 32'd5001);
    queue_sample(LevelPressed, 32'd5002);
    queue_sample(LevelReleased, 32'd5003);
    queue_sample(LevelReleased, 32'd5004);
    queue_sample(LevelPressed, 32'd5010);
    queue_sample(LevelPressed, 32'd5001);
    wait_drained();

    // Random phases, each with its own timing and pacing
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_DEBOUNCE, '0);
          write_reg(REG_DOUBLE_WINDOW, '1);
          write_reg(REG_LONG_PRESS, '0);
        end
        1: begin
          write_reg(REG_DEBOUNCE, '1);
          write_reg(REG_DOUBLE_WINDOW, '1);
          write_reg(REG_LONG_PRESS, '1);
        end
        2: begin
          write_reg(REG_DEBOUNCE, CfgDataWidth'($urandom_range(1, 20)));
          write_reg(REG_DOUBLE_WINDOW, CfgDataWidth'($urandom_range(100, 400)));
          write_reg(REG_LONG_PRESS, CfgDataWidth'($urandom_range(0, 500)));
        end
        default: begin
          if ($urandom_range(0, 3) == 0) write_reg(RegUnused, CfgDataWidth'($urandom));
          write_reg(REG_DEBOUNCE, pick_ms(20));
          write_reg(REG_DOUBLE_WINDOW, pick_ms(400));
          write_reg(REG_LONG_PRESS, pick_ms(500));
        end
      endcase
      @(posedge clk);
      sender_eager <= (phase == 2) || ($urandom_range(0, 2) == 0);
      receiver_eager <= (phase == 2) || ($urandom_range(0, 2) == 0);

      @(negedge clk);
      stim_ms = (phase == 3) ? 32'hFFFF_FF00 : $urandom;
      phase_start = pending_samples.size();
      while (pending_samples.size() - phase_start < PhaseSamples) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) queue_click(1'b0);
        else if (pick <= 7) queue_click(1'b1);
        else if (pick == 8) queue_sample(1'($urandom_range(0, 1)), $urandom);
        else queue_sample(1'($urandom_range(0, 1)),
                          stim_ms + $urandom_range(0, 2 * model_cfg.debounce_ms + 2));
      end

      // Hold off the receiver while samples keep coming, to fill the block
      if (phase == 2) begin
        while (pending_samples.size() > PhaseSamples - 15) @(negedge clk);
        @(posedge clk);
        holds_requested <= holds_requested + 1;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: %0d result words never arrived", $realtime, expected_results.size());
    end
    if (error_count == 0) begin
      $display("tb_button_click_classifier: done, clean");
    end else begin
      $display("tb_button_click_classifier: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(5_000_000);
    $display("tb_button_click_classifier: done, errors");
    $finish;
  end

endmodule
